/* rtl/core/stup_pkg.sv */
package stup_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int OFFSET_BITS = 16;
   localparam int BASE_BITS   = 6;
   localparam int CHAR_BITS   = 8;
   localparam int PHASE_BITS  = 3;
   localparam int PROD_BITS   = VALUE_BITS + BASE_BITS;

   localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
   localparam logic [BASE_BITS-1:0] BASE_ONE   = BASE_BITS'(1);
   localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
   localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);
   localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(36);

   localparam logic [PHASE_BITS-1:0] PH_DONE   = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_SPACE  = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_SIGNED = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_ZERO   = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_ZEROX  = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_DIGITS = 3'd5;

   localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'd9;
   localparam logic [CHAR_BITS-1:0] CH_CR     = 8'd13;
   localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'd32;
   localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'd43;
   localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'd45;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'd48;
   localparam logic [CHAR_BITS-1:0] CH_LOW_A  = 8'd97;
   localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'd88;
   localparam logic [CHAR_BITS-1:0] CH_LOW_X  = 8'd120;
   localparam logic [CHAR_BITS-1:0] NOT_DIGIT = 8'd255;

   // Digit value of a character (0-9, then a-z or A-Z as 10..35), or NOT_DIGIT.
   function automatic logic [CHAR_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] low;
      logic [CHAR_BITS-1:0] dec_off;
      logic [CHAR_BITS-1:0] alpha_off;
      low       = c | 8'd32;
      dec_off   = c - CH_ZERO;
      alpha_off = low - CH_LOW_A;
      if (dec_off < 8'd10) begin
         digit_of = dec_off;
      end else if (alpha_off < 8'd26) begin
         digit_of = alpha_off + 8'd10;
      end else begin
         digit_of = NOT_DIGIT;
      end
   endfunction

endpackage

/* rtl/core/string_to_unsigned_parser.sv */
// A request that ends the parse waits in the input register while the result register
// is full. Throughput: one character per cycle apart from that wait; the input register
// feeds digit logic (one 32x6 multiply-add and overflow check) into the parse state.
// Reset: parser waits for a string start, all parse state is zero, radix register
// holds 10, and both the input and result registers are empty.
module string_to_unsigned_parser
   import stup_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [7:0] char_code
   input  logic [7:0]                 req_tdata,
   // [0] string_start
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [31:0] parsed_value, [47:32] end_offset
   output logic [47:0]                rsp_tdata,
   // [0] converted, [1] overflowed
   output logic [1:0]                 rsp_tuser,
   input  logic                       csr_wr_en,
   input  logic [BASE_BITS-1:0]       csr_wr_data
);

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

   // Configuration register.
   logic [BASE_BITS-1:0]   number_base_ff;

   // Input register.
   logic                   in_valid_ff;
   logic [CHAR_BITS-1:0]   in_char_ff;
   logic                   in_start_ff;

   // Parse state.
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic                   seen_ff, seen_in;
   logic                   sat_ff, sat_in;
   logic [BASE_BITS-1:0]   base_ff, base_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] zpos_ff, zpos_in;

   // Result register.
   logic                   rsp_valid_ff;
   logic [VALUE_BITS-1:0]  rsp_value_ff;
   logic [OFFSET_BITS-1:0] rsp_offset_ff;
   logic                   rsp_conv_ff;
   logic                   rsp_ovf_ff;

   logic                   emit;
   logic [OFFSET_BITS-1:0] end_pos;
   logic [VALUE_BITS-1:0]  value_out;
   logic [OFFSET_BITS-1:0] offset_out;
   logic                   out_free;
   logic                   fire;

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      sat_inc = (v == OFF_MAX) ? OFF_MAX : v + OFFSET_BITS'(1);
   endfunction

   always_comb begin
      logic                  do_num;
      logic                  do_digit;
      logic [CHAR_BITS-1:0]  d;
      logic [PROD_BITS-1:0]  prod;
      logic                  is_space;
      logic [VALUE_BITS-1:0] acc_hold;

      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      sat_in   = sat_ff;
      base_in  = base_ff;
      pos_in   = pos_ff;
      zpos_in  = zpos_ff;
      emit     = 1'b0;
      end_pos  = '0;
      do_num   = 1'b0;
      do_digit = 1'b0;
      d        = digit_of(in_char_ff);
      prod     = '0;
      is_space = (in_char_ff == CH_SPACE) || (in_char_ff >= CH_TAB && in_char_ff <= CH_CR);

      if (in_start_ff) begin
         acc_in   = '0;
         neg_in   = 1'b0;
         seen_in  = 1'b0;
         sat_in   = 1'b0;
         pos_in   = '0;
         zpos_in  = '0;
         base_in  = number_base_ff;
         phase_in = PH_SPACE;
      end

      if (in_start_ff && (base_in == BASE_ONE || base_in > BASE_MAX)) begin
         emit     = 1'b1;
         phase_in = PH_DONE;
      end else begin
         case (phase_in)
            PH_SPACE: begin
               if (is_space) begin
                  pos_in = sat_inc(pos_in);
               end else if (in_char_ff == CH_PLUS || in_char_ff == CH_MINUS) begin
                  neg_in   = (in_char_ff == CH_MINUS);
                  pos_in   = sat_inc(pos_in);
                  phase_in = PH_SIGNED;
               end else begin
                  do_num = 1'b1;
               end
            end
            PH_SIGNED: begin
               do_num = 1'b1;
            end
            PH_ZERO: begin
               if (in_char_ff == CH_LOW_X || in_char_ff == CH_UP_X) begin
                  pos_in   = sat_inc(pos_in);
                  phase_in = PH_ZEROX;
               end else begin
                  if (base_in == BASE_AUTO) begin
                     base_in = BASE_OCT;
                  end
                  seen_in  = 1'b1;
                  phase_in = PH_DIGITS;
                  do_digit = 1'b1;
               end
            end
            PH_ZEROX: begin
               if (d < 8'd16) begin
                  base_in  = BASE_HEX;
                  phase_in = PH_DIGITS;
                  do_digit = 1'b1;
               end else begin
                  // A bare 0x prefix parses as the single zero before it.
                  seen_in = 1'b1;
                  emit    = 1'b1;
                  end_pos = sat_inc(zpos_in);
               end
            end
            PH_DIGITS: begin
               do_digit = 1'b1;
            end
            default: begin
            end
         endcase

         if (do_num) begin
            if ((base_in == BASE_AUTO || base_in == BASE_HEX) && in_char_ff == CH_ZERO) begin
               zpos_in  = pos_in;
               pos_in   = sat_inc(pos_in);
               phase_in = PH_ZERO;
            end else begin
               if (base_in == BASE_AUTO) begin
                  base_in = BASE_DEC;
               end
               phase_in = PH_DIGITS;
               do_digit = 1'b1;
            end
         end

         if (do_digit) begin
            if (d >= {{(CHAR_BITS-BASE_BITS){1'b0}}, base_in}) begin
               emit    = 1'b1;
               end_pos = pos_in;
            end else begin
               // Overflow exactly when acc * base + digit no longer fits the value width.
               prod = {{BASE_BITS{1'b0}}, acc_in} * {{VALUE_BITS{1'b0}}, base_in}
                      + {{(PROD_BITS-CHAR_BITS){1'b0}}, d};
               if (sat_in || prod[PROD_BITS-1:VALUE_BITS] != '0) begin
                  sat_in = 1'b1;
               end else begin
                  acc_in = prod[VALUE_BITS-1:0];
               end
               seen_in = 1'b1;
               pos_in  = sat_inc(pos_in);
            end
         end

         if (emit) begin
            phase_in = PH_DONE;
         end
      end

      // A request that ends the parse never adds a digit, so the result is taken from
      // the stored accumulator and stays off the multiply path.
      acc_hold = in_start_ff ? '0 : acc_ff;
      if (sat_in) begin
         value_out = {VALUE_BITS{1'b1}};
      end else if (neg_in) begin
         value_out = '0 - acc_hold;
      end else begin
         value_out = acc_hold;
      end
      offset_out = seen_in ? end_pos : '0;
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_RESET;
      end else if (csr_wr_en) begin
         number_base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         sat_ff   <= 1'b0;
         base_ff  <= '0;
         pos_ff   <= '0;
         zpos_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         seen_ff  <= seen_in;
         sat_ff   <= sat_in;
         base_ff  <= base_in;
         pos_ff   <= pos_in;
         zpos_ff  <= zpos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_value_ff  <= value_out;
         rsp_offset_ff <= offset_out;
         rsp_conv_ff   <= seen_in;
         rsp_ovf_ff    <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_offset_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_conv_ff};

`ifndef SYNTH
   a_no_conv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_conv_ff |-> rsp_offset_ff == '0 && !rsp_ovf_ff)
      else $error("result without digits carries an offset or overflow");

   a_ovf_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_value_ff == {VALUE_BITS{1'b1}})
      else $error("overflowed result is not saturated");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_char_ff) && $stable(in_start_ff))
      else $error("stalled request was dropped or changed");

   a_done_after_emit: assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> phase_ff == PH_DONE && rsp_valid_ff)
      else $error("parse did not finish after giving its result");
`endif

endmodule
